[rtl/core/asidga_pkg.sv]
// ----------------------------------------------------------------------------
// asidga_pkg
// shared constants, types and helpers of the asid generation allocator
// ----------------------------------------------------------------------------
`default_nettype none

package asidga_pkg;

	localparam int IDX_W    = 8;
	localparam int GEN_BITS = 24;
	localparam int TAG_W    = 32;
	localparam int HW_W     = 8;

	localparam int IDX_COUNT = 1 << IDX_W;
	localparam int WORD_W    = (IDX_COUNT < 32) ? IDX_COUNT : 32;
	localparam int POS_W     = $clog2(WORD_W);
	localparam int WORD_N    = IDX_COUNT / WORD_W;
	localparam int WSEL_W    = (WORD_N > 1) ? $clog2(WORD_N) : 1;

	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [GEN_BITS-1:0] gen_t;
	typedef logic [TAG_W-1:0]    tag_t;
	typedef logic [POS_W-1:0]    pos_t;
	typedef logic [WSEL_W-1:0]   wsel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_WRAP,
		ST_FINISH
	} state_t;

	typedef struct packed {
		wsel_t word;
		pos_t  pos;
		logic  set_en;
		idx_t  set_idx;
		logic  clear_all;
	} map_cmd_t;

	typedef struct packed {
		logic bit_used;
		logic found;
		pos_t found_pos;
	} map_rsp_t;

	function automatic tag_t tag_of(gen_t gen, idx_t idx);
		logic [63:0] t;
		t = (64'(gen) << IDX_W) | 64'(idx);
		return t[TAG_W-1:0];
	endfunction

	function automatic wsel_t word_of(idx_t idx);
		return WSEL_W'(idx >> POS_W);
	endfunction

	function automatic pos_t pos_of(idx_t idx);
		return idx[POS_W-1:0];
	endfunction

	function automatic idx_t idx_join(wsel_t word, pos_t pos);
		return (IDX_W'(word) << POS_W) | IDX_W'(pos);
	endfunction

endpackage

`default_nettype wire

[rtl/core/asidga_if.sv]
// ----------------------------------------------------------------------------
// asidga request / response channels
// valid/ready channels carrying context switch requests and asid results
// ----------------------------------------------------------------------------
`default_nettype none

interface asidga_req_if;
	logic                 valid;
	logic                 ready;
	asidga_pkg::tag_t     task_asid;
	logic                 is_kernel;
	logic                 same_group;

	modport source (output valid, task_asid, is_kernel, same_group, input ready);
	modport sink   (input valid, task_asid, is_kernel, same_group, output ready);
endinterface

interface asidga_rsp_if;
	logic                          valid;
	logic                          ready;
	asidga_pkg::tag_t              new_task_asid;
	logic [asidga_pkg::HW_W-1:0]   hw_asid;
	logic                          tlb_flush;

	modport source (output valid, new_task_asid, hw_asid, tlb_flush, input ready);
	modport sink   (input valid, new_task_asid, hw_asid, tlb_flush, output ready);
endinterface

`default_nettype wire

[rtl/core/asid_generation_allocator_unit.sv]
// ----------------------------------------------------------------------------
// asid_generation_allocator_unit
// allocates hardware asids per context switch with generation rollover
// ----------------------------------------------------------------------------
// One context switch is taken at a time. A kernel task, a task whose tag is
// of the current generation, or a task whose old index is still free goes
// straight from the check to the result. Otherwise the used-index map is
// scanned one 32-bit word per cycle from the last allocated index up to the
// last word; when no free index is found there, the generation rolls over
// (map cleared, flush made pending). The result sits in an output register;
// a new request is taken once the sequencer is idle.
`default_nettype none

module asid_generation_allocator_unit (
	input  wire           clk,
	input  wire           arst_n,
	asidga_req_if.sink    req,
	asidga_rsp_if.source  rsp
);

	asidga_pkg::map_cmd_t map_cmd;
	asidga_pkg::map_rsp_t map_rsp;

	asidga_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.map_cmd (map_cmd),
		.map_rsp (map_rsp)
	);

	asidga_map u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (map_cmd),
		.rsp    (map_rsp)
	);

endmodule

`default_nettype wire

[rtl/core/asidga_map.sv]
// ----------------------------------------------------------------------------
// asidga_map
// used-index bitmap held as words, with one word read and a find-first-free
// ----------------------------------------------------------------------------
`default_nettype none

module asidga_map (
	input  wire                   clk,
	input  wire                   arst_n,
	input  asidga_pkg::map_cmd_t  cmd,
	output asidga_pkg::map_rsp_t  rsp
);

	logic [asidga_pkg::WORD_W-1:0] words_q [asidga_pkg::WORD_N];
	logic [asidga_pkg::WORD_W-1:0] rd_word;
	logic [asidga_pkg::WORD_W-1:0] free_vec;
	logic [asidga_pkg::WORD_W-1:0] set_bit;
	asidga_pkg::wsel_t             set_word;
	asidga_pkg::pos_t              set_pos;

	assign set_word = asidga_pkg::word_of(cmd.set_idx);
	assign set_pos  = asidga_pkg::pos_of(cmd.set_idx);
	assign set_bit  = asidga_pkg::WORD_W'(1) << set_pos;
	assign rd_word  = words_q[cmd.word];
	assign free_vec = ~rd_word & ({asidga_pkg::WORD_W{1'b1}} << cmd.pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < asidga_pkg::WORD_N; w++) begin
				words_q[w] <= '0;
			end
		end else begin
			for (int w = 0; w < asidga_pkg::WORD_N; w++) begin
				words_q[w] <= (cmd.clear_all ? '0 : words_q[w]) |
					((cmd.set_en && (set_word == asidga_pkg::WSEL_W'(w))) ? set_bit : '0);
			end
		end
	end

	always_comb begin
		rsp.bit_used  = rd_word[cmd.pos];
		rsp.found     = |free_vec;
		rsp.found_pos = '0;
		for (int i = asidga_pkg::WORD_W - 1; i >= 0; i--) begin
			if (free_vec[i]) begin
				rsp.found_pos = asidga_pkg::POS_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/asidga_seq.sv]
// ----------------------------------------------------------------------------
// asidga_seq
// sequencer: classifies a switch, drives the map scan, handles rollover
// ----------------------------------------------------------------------------
`default_nettype none

module asidga_seq (
	input  wire                   clk,
	input  wire                   arst_n,
	asidga_req_if.sink            req,
	asidga_rsp_if.source          rsp,
	output asidga_pkg::map_cmd_t  map_cmd,
	input  asidga_pkg::map_rsp_t  map_rsp
);

	asidga_pkg::state_t state_q, state_d;

	asidga_pkg::tag_t  task_q;
	logic              kern_q;
	logic              grp_q;
	logic              keep_q;
	asidga_pkg::gen_t  gen_q;
	asidga_pkg::idx_t  start_q;
	logic              flushp_q;
	asidga_pkg::wsel_t word_q;
	asidga_pkg::pos_t  low_q;
	asidga_pkg::idx_t  idx_q;

	logic              out_valid_q;
	asidga_pkg::tag_t  out_tag_q;
	logic [asidga_pkg::HW_W-1:0] out_hw_q;
	logic              out_flush_q;

	asidga_pkg::idx_t  old_idx;
	asidga_pkg::idx_t  from_idx;
	asidga_pkg::idx_t  found_idx;
	asidga_pkg::gen_t  gen_inc;
	logic              gen_match;
	logic              can_reclaim;
	logic              out_free;
	logic              last_word;

	assign old_idx   = task_q[asidga_pkg::IDX_W-1:0];
	assign from_idx  = (start_q == '0) ? asidga_pkg::IDX_W'(1) : start_q;
	assign found_idx = asidga_pkg::idx_join(word_q, map_rsp.found_pos);
	assign gen_inc   = gen_q + asidga_pkg::GEN_BITS'(1);
	assign gen_match = (task_q >> asidga_pkg::IDX_W) ==
		(asidga_pkg::tag_of(gen_q, '0) >> asidga_pkg::IDX_W);
	assign can_reclaim = (task_q != '0) && (old_idx != '0) && !map_rsp.bit_used;
	assign out_free  = !out_valid_q || rsp.ready;
	assign last_word = (word_q == asidga_pkg::WSEL_W'(asidga_pkg::WORD_N - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			asidga_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_d = asidga_pkg::ST_CHECK;
				end
			end
			asidga_pkg::ST_CHECK: begin
				if (kern_q || gen_match || can_reclaim) begin
					state_d = asidga_pkg::ST_FINISH;
				end else begin
					state_d = asidga_pkg::ST_SCAN;
				end
			end
			asidga_pkg::ST_SCAN: begin
				if (map_rsp.found) begin
					state_d = asidga_pkg::ST_FINISH;
				end else if (last_word) begin
					state_d = asidga_pkg::ST_WRAP;
				end
			end
			asidga_pkg::ST_WRAP: begin
				state_d = asidga_pkg::ST_FINISH;
			end
			asidga_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = asidga_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = asidga_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs to the map and handshake
	always_comb begin
		req.ready         = (state_q == asidga_pkg::ST_IDLE);
		map_cmd.word      = word_q;
		map_cmd.pos       = low_q;
		map_cmd.set_en    = 1'b0;
		map_cmd.set_idx   = found_idx;
		map_cmd.clear_all = 1'b0;
		unique case (state_q)
			asidga_pkg::ST_CHECK: begin
				map_cmd.word    = asidga_pkg::word_of(old_idx);
				map_cmd.pos     = asidga_pkg::pos_of(old_idx);
				map_cmd.set_idx = old_idx;
				map_cmd.set_en  = !kern_q && !gen_match && can_reclaim;
			end
			asidga_pkg::ST_SCAN: begin
				map_cmd.set_en = map_rsp.found;
			end
			asidga_pkg::ST_WRAP: begin
				map_cmd.clear_all = 1'b1;
				map_cmd.set_en    = 1'b1;
				map_cmd.set_idx   = asidga_pkg::IDX_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= asidga_pkg::ST_IDLE;
			gen_q       <= asidga_pkg::GEN_BITS'(1);
			start_q     <= asidga_pkg::IDX_W'(1);
			flushp_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == asidga_pkg::ST_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				asidga_pkg::ST_SCAN: begin
					if (map_rsp.found) begin
						start_q <= found_idx;
					end
				end
				asidga_pkg::ST_WRAP: begin
					gen_q    <= (gen_inc == '0) ? asidga_pkg::GEN_BITS'(1) : gen_inc;
					flushp_q <= 1'b1;
					start_q  <= asidga_pkg::IDX_W'(1);
				end
				asidga_pkg::ST_FINISH: begin
					if (out_free && !grp_q) begin
						flushp_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			asidga_pkg::ST_IDLE: begin
				if (req.valid) begin
					task_q <= req.task_asid;
					kern_q <= req.is_kernel;
					grp_q  <= req.same_group;
				end
			end
			asidga_pkg::ST_CHECK: begin
				keep_q <= kern_q || gen_match;
				word_q <= asidga_pkg::word_of(from_idx);
				low_q  <= asidga_pkg::pos_of(from_idx);
				if (kern_q) begin
					idx_q <= '0;
				end else begin
					idx_q <= old_idx;
				end
			end
			asidga_pkg::ST_SCAN: begin
				if (map_rsp.found) begin
					idx_q <= found_idx;
				end else begin
					word_q <= word_q + asidga_pkg::WSEL_W'(1);
					low_q  <= '0;
				end
			end
			asidga_pkg::ST_WRAP: begin
				idx_q <= asidga_pkg::IDX_W'(1);
			end
			asidga_pkg::ST_FINISH: begin
				if (out_free) begin
					out_tag_q   <= keep_q ? task_q : asidga_pkg::tag_of(gen_q, idx_q);
					out_hw_q    <= asidga_pkg::HW_W'(idx_q);
					out_flush_q <= !grp_q && flushp_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.new_task_asid = out_tag_q;
	assign rsp.hw_asid       = out_hw_q;
	assign rsp.tlb_flush     = out_flush_q;

endmodule

`default_nettype wire
